[rtl/prrtp_pkg.sv]
// ----------------------------------------------------------------------------
// prrtp_pkg: shared types and constants
// Payload structs, action codes, run states and controller states of the
// priority round-robin thread picker.
// ----------------------------------------------------------------------------
package prrtp_pkg;

  localparam int DEF_SLOTS     = 32;
  localparam int DEF_PRIO_BITS = 4;

  localparam int ACT_W  = 4;
  localparam int SLOT_W = 5;
  localparam int REQP_W = 4;
  localparam int CNT_W  = 6;
  localparam int EXT_W  = 9;   // holds any slot index up to 256
  localparam int PEXT_W = 16;  // holds any priority of up to 16 bits

  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CREATE  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_READY   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_RUNNING = 4'd2;
  localparam logic [ACT_W-1:0] ACT_BLOCKED = 4'd3;
  localparam logic [ACT_W-1:0] ACT_ZOMBIE  = 4'd4;
  localparam logic [ACT_W-1:0] ACT_DEAD    = 4'd5;
  localparam logic [ACT_W-1:0] ACT_KILL    = 4'd6;
  localparam logic [ACT_W-1:0] ACT_PICK    = 4'd7;
  localparam logic [ACT_W-1:0] ACT_SET_CUR = 4'd8;

  typedef enum logic [2:0] {
    RS_READY   = 3'd0,
    RS_RUNNING = 3'd1,
    RS_BLOCKED = 3'd2,
    RS_ZOMBIE  = 3'd3,
    RS_DEAD    = 3'd4
  } run_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAX,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
    logic [REQP_W-1:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] current_slot;
    logic [SLOT_W-1:0] picked_slot;
    logic              found;
  } out_t;

  // write enables of the slot memory
  typedef struct packed {
    logic we_state;
    logic we_prio;
  } mem_wr_t;

endpackage

[rtl/prrtp_slot_mem.sv]
// ----------------------------------------------------------------------------
// prrtp_slot_mem: slot table storage
// Run state and priority arrays, one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module prrtp_slot_mem #(
  parameter int SLOTS     = prrtp_pkg::DEF_SLOTS,
  parameter int PRIO_BITS = prrtp_pkg::DEF_PRIO_BITS,
  localparam int IDX_W    = $clog2(SLOTS)
) (
  input  logic                    clk,
  input  prrtp_pkg::mem_wr_t      wr,
  input  logic [IDX_W-1:0]        waddr,
  input  prrtp_pkg::run_state_t   wstate,
  input  logic [PRIO_BITS-1:0]    wprio,
  input  logic [IDX_W-1:0]        raddr,
  output prrtp_pkg::run_state_t   rstate,
  output logic [PRIO_BITS-1:0]    rprio
);
  import prrtp_pkg::*;

  run_state_t           state_mem [SLOTS];
  logic [PRIO_BITS-1:0] prio_mem  [SLOTS];

  run_state_t           rstate_r;
  logic [PRIO_BITS-1:0] rprio_r;

  always_ff @(posedge clk) begin
    if (wr.we_state) begin
      state_mem[waddr] <= wstate;
    end
    if (wr.we_prio) begin
      prio_mem[waddr] <= wprio;
    end
  end

  always_ff @(posedge clk) begin
    rstate_r <= state_mem[raddr];
    rprio_r  <= prio_mem[raddr];
  end

  assign rstate = rstate_r;
  assign rprio  = rprio_r;

endmodule

[rtl/prrtp_ctrl.sv]
// ----------------------------------------------------------------------------
// prrtp_ctrl: action decoder and pick sequencer
// Valid bits, current slot, running count, and the two-pass pick walk over
// the slot memory.
// ----------------------------------------------------------------------------
module prrtp_ctrl #(
  parameter int SLOTS     = prrtp_pkg::DEF_SLOTS,
  parameter int PRIO_BITS = prrtp_pkg::DEF_PRIO_BITS,
  localparam int IDX_W    = $clog2(SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  prrtp_pkg::in_t          in_data,
  output logic                    in_stall,
  output logic                    res_vld,
  output prrtp_pkg::out_t         res,
  input  logic                    res_take,
  output prrtp_pkg::mem_wr_t      mem_wr,
  output logic [IDX_W-1:0]        waddr,
  output prrtp_pkg::run_state_t   wstate,
  output logic [PRIO_BITS-1:0]    wprio,
  output logic [IDX_W-1:0]        raddr,
  input  prrtp_pkg::run_state_t   rstate,
  input  logic [PRIO_BITS-1:0]    rprio
);
  import prrtp_pkg::*;

  localparam int K_W = $clog2(SLOTS + 1);
  localparam logic [K_W-1:0]   K_LAST   = K_W'(SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == IDX_LAST) begin
      r = '0;
    end else begin
      r = a + IDX_W'(1);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] a);
    logic [EXT_W-1:0] e;
    e = EXT_W'(a);
    return e[SLOT_W-1:0];
  endfunction

  function automatic run_state_t act_state(input logic [ACT_W-1:0] act);
    run_state_t s;
    case (act)
      ACT_READY:   s = RS_READY;
      ACT_RUNNING: s = RS_RUNNING;
      ACT_BLOCKED: s = RS_BLOCKED;
      ACT_ZOMBIE:  s = RS_ZOMBIE;
      default:     s = RS_DEAD;
    endcase
    return s;
  endfunction

  ctrl_state_t          st_r, st_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PRIO_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]     a_r, a_nxt;
  logic [IDX_W-1:0]     aq_r;
  logic                 vq_r;
  logic [K_W-1:0]       k_r, k_nxt;
  out_t                 res_r, res_nxt;

  logic                 accept;
  logic [EXT_W-1:0]     slot_ext;
  logic                 in_range;
  logic [IDX_W-1:0]     sidx;
  logic                 sval;
  logic [PEXT_W-1:0]    pr_ext;
  logic                 idle_only;
  logic                 ready_hit;
  logic                 hit;
  logic                 max_upd;

  assign accept    = in_valid && (st_r == ST_IDLE);
  assign slot_ext  = EXT_W'(in_data.slot);
  assign in_range  = slot_ext < EXT_W'(SLOTS);
  assign sidx      = slot_ext[IDX_W-1:0];
  assign sval      = in_range && valid_r[sidx];
  assign pr_ext    = PEXT_W'(in_data.priority_req);
  assign idle_only = (cnt_r == CNT_W'(1)) && (cur_r == '0);

  // returned read data belongs to the address issued in the previous cycle
  assign ready_hit = (k_r != '0) && vq_r && (rstate == RS_READY);
  assign hit       = ready_hit && (rprio >= best_r);
  assign max_upd   = ready_hit && (rprio > best_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_PICK && !idle_only) begin
            st_nxt = ST_MAX;
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_MAX: begin
        if (k_r == K_LAST) begin
          st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || k_r == K_LAST) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    valid_nxt = valid_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    best_nxt  = best_r;
    a_nxt     = a_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    mem_wr    = '0;
    waddr     = sidx;
    wstate    = RS_DEAD;
    wprio     = pr_ext[PRIO_BITS-1:0];
    raddr     = a_r;
    in_stall  = (st_r != ST_IDLE);
    res_vld   = (st_r == ST_DONE);
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_CREATE: begin
              if (in_range) begin
                valid_nxt[sidx] = 1'b1;
                mem_wr.we_prio  = 1'b1;
                // a fresh entry gets the dead state written; a valid slot keeps its state
                mem_wr.we_state = !sval;
                if (cnt_r < COUNT_MAX) begin
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
              end
            end
            ACT_READY, ACT_RUNNING, ACT_BLOCKED, ACT_ZOMBIE, ACT_DEAD: begin
              if (sval && !(in_data.action == ACT_ZOMBIE && in_data.slot == '0)) begin
                mem_wr.we_state = 1'b1;
                wstate          = act_state(in_data.action);
              end
            end
            ACT_KILL: begin
              if (sval && in_data.slot != '0) begin
                valid_nxt[sidx] = 1'b0;
                mem_wr.we_state = 1'b1;
                if (cnt_r > CNT_W'(1)) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
                cur_nxt = '0;
              end
            end
            ACT_PICK: begin
              a_nxt    = '0;
              k_nxt    = '0;
              best_nxt = '0;
            end
            ACT_SET_CUR: begin
              if (in_range) begin
                cur_nxt = sidx;
              end
            end
            default: ;
          endcase
          res_nxt.current_slot = to_slot(cur_nxt);
          res_nxt.picked_slot  = '0;
          res_nxt.found        = 1'b0;
        end
      end
      ST_MAX: begin
        k_nxt = k_r + K_W'(1);
        a_nxt = wrap_inc(a_r);
        if (max_upd) begin
          best_nxt = rprio;
        end
        if (k_r == K_LAST) begin
          k_nxt = '0;
          a_nxt = wrap_inc(cur_r);
        end
      end
      ST_SCAN: begin
        k_nxt = k_r + K_W'(1);
        a_nxt = wrap_inc(a_r);
        if (hit) begin
          cur_nxt              = aq_r;
          res_nxt.current_slot = to_slot(aq_r);
          res_nxt.picked_slot  = to_slot(aq_r);
          res_nxt.found        = 1'b1;
        end else if (k_r == K_LAST) begin
          cur_nxt = '0;
          res_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      valid_r <= '0;
      cur_r   <= '0;
      cnt_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      valid_r <= valid_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    a_r    <= a_nxt;
    k_r    <= k_nxt;
    res_r  <= res_nxt;
    aq_r   <= a_r;
    vq_r   <= valid_r[a_r];
  end

  // a found pick always becomes the current slot
  a_found_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && res_r.found) |-> (res_r.current_slot == res_r.picked_slot))
    else $error("found pick not made current");

  a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && !res_r.found) |-> (res_r.picked_slot == '0))
    else $error("picked slot set without a hit");

  // count never drops back to zero once set
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |=> (cnt_r != '0))
    else $error("running count reached zero");

  // table writes happen only on an accepted action, never during a walk
  a_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr.we_state || mem_wr.we_prio) |-> (st_r == ST_IDLE && in_valid))
    else $error("slot memory written outside an accepted action");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MAX || st_r == ST_SCAN) |-> (k_r <= K_LAST))
    else $error("walk counter overran the table");

endmodule

[rtl/priority_round_robin_thread_picker_unit.sv]
// ----------------------------------------------------------------------------
// priority_round_robin_thread_picker_unit: thread slot scheduler top level
// Slot table in memory, action sequencer, and output result register.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one scheduler action (create, state
// change, kill, pick, set current) and yields exactly one result transfer
// carrying the current slot, the picked slot and a found flag. The block
// works on one action at a time. Create, state changes, kill and set current
// pass from the input transfer through the controller's done state to the
// output register. A pick reads the slot table through the single read port
// of the slot memory twice, first to find the highest ready priority and then
// to scan round-robin from the slot after the current one; the scan ends
// early on the first hit, and a pick with only the idle slot running takes
// the same short path. A finished result sits in the output register, so the
// next action is taken while the previous result waits for its transfer. Slot
// valid bits live in flip-flops cleared by reset: there is no clearing pass,
// and the block takes actions from the first cycle after reset.
// ----------------------------------------------------------------------------
module priority_round_robin_thread_picker_unit #(
  parameter int SLOTS     = prrtp_pkg::DEF_SLOTS,
  parameter int PRIO_BITS = prrtp_pkg::DEF_PRIO_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  prrtp_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output prrtp_pkg::out_t out_data
);
  import prrtp_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  // controller <-> slot memory
  mem_wr_t              mem_wr;
  logic [IDX_W-1:0]     waddr;
  run_state_t           wstate;
  logic [PRIO_BITS-1:0] wprio;
  logic [IDX_W-1:0]     raddr;
  run_state_t           rstate;
  logic [PRIO_BITS-1:0] rprio;

  // controller -> output register
  logic res_vld;
  out_t res;
  logic res_take;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  prrtp_slot_mem #(
    .SLOTS     (SLOTS),
    .PRIO_BITS (PRIO_BITS)
  ) u_mem (
    .clk    (clk),
    .wr     (mem_wr),
    .waddr  (waddr),
    .wstate (wstate),
    .wprio  (wprio),
    .raddr  (raddr),
    .rstate (rstate),
    .rprio  (rprio)
  );

  prrtp_ctrl #(
    .SLOTS     (SLOTS),
    .PRIO_BITS (PRIO_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .res_vld  (res_vld),
    .res      (res),
    .res_take (res_take),
    .mem_wr   (mem_wr),
    .waddr    (waddr),
    .wstate   (wstate),
    .wprio    (wprio),
    .raddr    (raddr),
    .rstate   (rstate),
    .rprio    (rprio)
  );

  // output register: loads when empty or when its result transfers this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_vld && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
